>>> hw/rtl/sha1_message_digest_defines.svh
// Assertion macros for the SHA-1 message digest block.
// Used by files that assert; they expect clk_i and rst_ni in scope.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SHA1MD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest block.
// No dependencies; used by sha1md_round and sha1_message_digest.
package sha1md_pkg;

  localparam int unsigned NumWords = 5;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } out_t;

  // Working variables of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam logic [0:NumWords-1][31:0] HInit = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] RoundStage1 = 7'd20;
  localparam logic [6:0] RoundStage2 = 7'd40;
  localparam logic [6:0] RoundStage3 = 7'd60;
  localparam logic [6:0] LastRound   = 7'd79;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenPos   = 6'd56;
  localparam logic [5:0] LastByte = 6'd63;
  localparam logic [2:0] LastWord = 3'(NumWords - 1);

endpackage

>>> hw/rtl/sha1md_round.sv
// One SHA-1 round: round function, constant select and the five-term add.
// Depends on sha1md_pkg.
module sha1md_round import sha1md_pkg::*; (
  input  logic [6:0]  round_i,
  input  work_t       work_i,
  input  logic [31:0] sched_i,
  output work_t       work_o
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;

  always_comb begin
    if (round_i < RoundStage1) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = K0;
    end else if (round_i < RoundStage2) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K1;
    end else if (round_i < RoundStage3) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = K3;
    end
    tmp = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + sched_i;
    work_o.a = tmp;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

>>> hw/rtl/sha1_message_digest.sv
// SHA-1 digest of a byte stream. Bytes are taken one per cycle while a block
// fills; every 64th byte starts a compression (80 rounds through the single
// round unit, then the chain add), and ready stays low during compression.
// An end word pads one byte per cycle, runs one or two compressions, then
// offers the five digest words, most significant first, through an output
// register; the next message may start while the last word waits.
// Depends on sha1md_pkg, sha1md_round and sha1_message_digest_defines.svh.
`include "sha1_message_digest_defines.svh"

module sha1_message_digest import sha1md_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [5:0]                  fill_q, fill_d;
  logic [63:0]                 bit_len_q, bit_len_d;
  logic [0:NumWords-1][31:0]   chain_q, chain_d;
  logic                        fin_q, fin_d;
  logic                        mark_q, mark_d;
  logic                        len_q, len_d;
  logic [6:0]                  rnd_q, rnd_d;
  logic [2:0]                  idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  logic [511:0]                blk_q, blk_d;
  work_t                       work_q, work_d;
  out_t                        out_q, out_d;

  work_t       round_work;
  logic [31:0] sched_mix;
  logic [31:0] sched_new;
  logic [7:0]  pad_byte;

  sha1md_round u_round (
    .round_i (rnd_q),
    .work_i  (work_q),
    .sched_i (blk_q[511:480]),
    .work_o  (round_work)
  );

  // Window holds W[t] .. W[t+15], W[t] at the top
  assign sched_mix = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  always_comb begin
    if (!mark_q) begin
      pad_byte = PadByte;
    end else if (len_q || fill_q == LenPos) begin
      pad_byte = bit_len_q[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bit_len_d   = bit_len_q;
    chain_d     = chain_q;
    fin_d       = fin_q;
    mark_d      = mark_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    blk_d       = blk_q;
    work_d      = work_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          fin_d  = in_i.end_of_message;
          mark_d = 1'b0;
          len_d  = 1'b0;
          if (in_i.byte_present) begin
            blk_d     = {blk_q[503:0], in_i.msg_byte};
            fill_d    = fill_q + 6'd1;
            bit_len_d = bit_len_q + 64'd8;
          end
          if (in_i.byte_present && fill_q == LastByte) begin
            work_d  = chain_q;
            rnd_d   = '0;
            state_d = ST_ROUND;
          end else if (in_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        blk_d  = {blk_q[503:0], pad_byte};
        fill_d = fill_q + 6'd1;
        mark_d = 1'b1;
        if (mark_q && fill_q == LenPos) begin
          len_d = 1'b1;
        end
        if (fill_q == LastByte) begin
          work_d  = chain_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        work_d = round_work;
        blk_d  = {blk_q[479:0], sched_new};
        rnd_d  = rnd_q + 7'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_d[0] = chain_q[0] + work_q.a;
        chain_d[1] = chain_q[1] + work_q.b;
        chain_d[2] = chain_q[2] + work_q.c;
        chain_d[3] = chain_q[3] + work_q.d;
        chain_d[4] = chain_q[4] + work_q.e;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (len_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.digest_word = chain_q[idx_q];
          out_d.word_index  = idx_q;
          out_d.final_word  = (idx_q == LastWord);
          out_valid_d       = 1'b1;
          idx_d             = idx_q + 3'd1;
          if (idx_q == LastWord) begin
            // restart the chain for the next message
            chain_d   = HInit;
            bit_len_d = '0;
            fill_d    = '0;
            fin_d     = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      bit_len_q   <= '0;
      chain_q     <= HInit;
      fin_q       <= 1'b0;
      mark_q      <= 1'b0;
      len_q       <= 1'b0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bit_len_q   <= bit_len_d;
      chain_q     <= chain_d;
      fin_q       <= fin_d;
      mark_q      <= mark_d;
      len_q       <= len_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `SHA1MD_ASSERT_NEXT(a_last_round_adds, rnd_q == LastRound, state_q == ST_ADD, "chain add missed")
  `SHA1MD_ASSERT_NOW(a_round_block_full, state_q == ST_ROUND, fill_q == '0, "partial block")
  `SHA1MD_ASSERT_NOW(a_emit_after_length, state_q == ST_EMIT, fin_q && len_q, "emit before length")
  `SHA1MD_ASSERT_NOW(a_pad_only_final, state_q == ST_PAD, fin_q, "padding outside finalization")

endmodule
